// ----- hdl/pcr_pkg.sv -----
// Shared types and constants of the polyline corner rounding block.
`default_nettype none
package pcr_pkg;

	localparam int AMT_W = 31;

	localparam logic [1:0] KIND_MOVE  = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_CURVE = 2'd2;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_BOTH  = 2'd3;

	localparam logic [1:0] POS_EMPTY = 2'd0;
	localparam logic [1:0] POS_ONE   = 2'd1;
	localparam logic [1:0] POS_MANY  = 2'd2;

	localparam logic [0:0] REG_SHORTEN_LEN = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_APPLY,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SEL_POINT,
		SEL_MID_SE,
		SEL_MID_X1,
		SEL_X1,
		SEL_X2
	} sel_t;

	typedef struct packed {
		logic       load_in;
		logic       calc;
		logic       mul;
		logic       dinit;
		logic       dstep;
		logic       apply;
		logic       emit;
		sel_t       sel;
		logic [1:0] kind;
		logic       run_end;
		logic       path_end;
		logic       commit_prev;
		logic       commit_se;
		logic [1:0] mode;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/pcr_datapath.sv -----
// Datapath: vertex registers, slope multiply, iterative divider and output register.
`default_nettype none
module pcr_datapath
	import pcr_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	input  wire logic        [AMT_W-1:0]       shorten_len,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic             [1:0]             draw_kind,
	output logic signed      [COORD_WIDTH-1:0] out_x,
	output logic signed      [COORD_WIDTH-1:0] out_y,
	output logic                               run_end,
	output logic                               path_end
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int PW   = CW + AMT_W;
	localparam int CMPW = CW + AMT_W + 3;

	logic signed [CW-1:0] px_q, py_q, prev_x_q, prev_y_q, se_x_q, se_y_q;
	logic signed [DW-1:0] run_s1, rise_s1;
	logic        [CW-1:0] dx_s1, dy_s1, major_s1, minor_s1;
	logic        [PW-1:0] prod_q;
	logic        [DW-1:0] rem_q;
	logic        [CW-1:0] num_q, quot_q;
	logic signed [CW-1:0] x1n_q, y1n_q, x2n_q, y2n_q;
	logic                 out_valid_q;

	// Difference stage.
	logic signed [DW-1:0] run_c, rise_c;
	logic        [DW-1:0] dx_c, dy_c;

	always_comb begin
		run_c  = {prev_x_q[CW-1], prev_x_q} - {px_q[CW-1], px_q};
		rise_c = {prev_y_q[CW-1], prev_y_q} - {py_q[CW-1], py_q};
		dx_c   = run_c[DW-1] ? DW'(-run_c) : DW'(run_c);
		dy_c   = rise_c[DW-1] ? DW'(-rise_c) : DW'(rise_c);
	end

	// Restoring divider step.
	logic [DW-1:0] trial;
	logic          qbit;

	always_comb begin
		trial = {rem_q[CW-1:0], num_q[CW-1]};
		qbit  = (trial >= {1'b0, major_s1});
	end

	// Offset and shortened endpoints.
	logic        [CMPW-1:0] s_w, maj_w;
	logic                   col_both, col_start, col_end;
	logic signed [DW-1:0]   s_pos, s_neg, q_pos, q_neg, ox, oy;
	logic signed [DW-1:0]   run_adj, rise_adj, mx, my;
	logic signed [DW-1:0]   x1e, y1e, x2e, y2e, x1a, y1a, x2a, y2a;

	always_comb begin
		s_w       = CMPW'(shorten_len);
		maj_w     = CMPW'(major_s1);
		col_both  = (cmd.mode == MODE_BOTH) && ((s_w << 1) > maj_w);
		col_start = (cmd.mode == MODE_START) && (s_w > maj_w);
		col_end   = (cmd.mode == MODE_END) && (s_w > maj_w);
		// The amount only reaches the offsets when it is no larger than the major axis.
		s_pos     = $signed(DW'(shorten_len));
		s_neg     = -s_pos;
		q_pos     = $signed({1'b0, quot_q});
		q_neg     = -q_pos;
		if (run_s1 == '0) begin
			ox = '0;
			oy = rise_s1[DW-1] ? s_neg : s_pos;
		end else if (rise_s1 == '0) begin
			oy = '0;
			ox = run_s1[DW-1] ? s_neg : s_pos;
		end else if (dy_s1 > dx_s1) begin
			oy = rise_s1[DW-1] ? s_neg : s_pos;
			ox = run_s1[DW-1] ? q_neg : q_pos;
		end else if (dy_s1 < dx_s1) begin
			ox = run_s1[DW-1] ? s_neg : s_pos;
			oy = rise_s1[DW-1] ? q_neg : q_pos;
		end else begin
			ox = '0;
			oy = '0;
		end
		x1e      = {prev_x_q[CW-1], prev_x_q};
		y1e      = {prev_y_q[CW-1], prev_y_q};
		x2e      = {px_q[CW-1], px_q};
		y2e      = {py_q[CW-1], py_q};
		// Halving truncates toward zero.
		run_adj  = run_s1 + $signed({{(DW-1){1'b0}}, run_s1[DW-1]});
		rise_adj = rise_s1 + $signed({{(DW-1){1'b0}}, rise_s1[DW-1]});
		mx       = x1e - (run_adj >>> 1);
		my       = y1e - (rise_adj >>> 1);
		x1a      = x1e;
		y1a      = y1e;
		x2a      = x2e;
		y2a      = y2e;
		if (col_both) begin
			x1a = mx;
			y1a = my;
			x2a = mx;
			y2a = my;
		end else if (col_start) begin
			x1a = x2e;
			y1a = y2e;
		end else if (col_end) begin
			x2a = x1e;
			y2a = y1e;
		end else begin
			if (cmd.mode[1]) begin
				x2a = x2e + ox;
				y2a = y2e + oy;
			end
			if (cmd.mode[0]) begin
				x1a = x1e - ox;
				y1a = y1e - oy;
			end
		end
	end

	function automatic logic signed [CW-1:0] mid_pt(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [DW-1:0] ae, be, lo, df;
		ae = {a[CW-1], a};
		be = {b[CW-1], b};
		if (ae < be) begin
			lo = ae;
			df = be - ae;
		end else begin
			lo = be;
			df = ae - be;
		end
		return CW'(lo + (df >> 1));
	endfunction

	logic signed [CW-1:0] sel_x, sel_y;

	always_comb begin
		case (cmd.sel)
			SEL_MID_SE: begin
				sel_x = mid_pt(se_x_q, prev_x_q);
				sel_y = mid_pt(se_y_q, prev_y_q);
			end
			SEL_MID_X1: begin
				sel_x = mid_pt(x1n_q, prev_x_q);
				sel_y = mid_pt(y1n_q, prev_y_q);
			end
			SEL_X1: begin
				sel_x = x1n_q;
				sel_y = y1n_q;
			end
			SEL_X2: begin
				sel_x = x2n_q;
				sel_y = y2n_q;
			end
			default: begin
				sel_x = px_q;
				sel_y = py_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		if (cmd.calc) begin
			run_s1   <= run_c;
			rise_s1  <= rise_c;
			dx_s1    <= dx_c[CW-1:0];
			dy_s1    <= dy_c[CW-1:0];
			major_s1 <= (dx_c > dy_c) ? dx_c[CW-1:0] : dy_c[CW-1:0];
			minor_s1 <= (dx_c > dy_c) ? dy_c[CW-1:0] : dx_c[CW-1:0];
		end
		if (cmd.mul) begin
			prod_q <= PW'(shorten_len) * PW'(minor_s1);
		end
		if (cmd.dinit) begin
			rem_q  <= DW'(prod_q[PW-1:CW]);
			num_q  <= prod_q[CW-1:0];
			quot_q <= '0;
		end
		if (cmd.dstep) begin
			rem_q  <= qbit ? (trial - {1'b0, major_s1}) : trial;
			num_q  <= num_q << 1;
			quot_q <= {quot_q[CW-2:0], qbit};
		end
		if (cmd.apply) begin
			x1n_q <= x1a[CW-1:0];
			y1n_q <= y1a[CW-1:0];
			x2n_q <= x2a[CW-1:0];
			y2n_q <= y2a[CW-1:0];
		end
		if (cmd.emit) begin
			draw_kind <= cmd.kind;
			out_x     <= sel_x;
			out_y     <= sel_y;
			run_end   <= cmd.run_end;
			path_end  <= cmd.path_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			se_x_q      <= '0;
			se_y_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit_prev) begin
				prev_x_q <= px_q;
				prev_y_q <= py_q;
			end
			if (cmd.commit_se) begin
				se_x_q <= x2n_q;
				se_y_q <= y2n_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ----- hdl/pcr_ctrl.sv -----
// Controller: sequences one vertex through the datapath and its results.
`default_nettype none
module pcr_ctrl
	import pcr_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic    last_point,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam int CNTW = $clog2(COORD_WIDTH);

	state_t          state_q, state_d;
	logic [1:0]      pos_q, mode_q, mode_d, k_q;
	logic            last_q, final_res;
	logic [CNTW-1:0] cnt_q;

	always_comb begin
		if (pos_q == POS_ONE) begin
			mode_d = last_point ? MODE_NONE : MODE_END;
		end else if (pos_q == POS_MANY) begin
			mode_d = last_point ? MODE_START : MODE_BOTH;
		end else begin
			mode_d = MODE_NONE;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.mode  = mode_q;
		cmd.sel   = SEL_POINT;
		cmd.kind  = KIND_MOVE;
		final_res = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = (pos_q == POS_ONE || pos_q == POS_MANY) ? ST_CALC : ST_EMIT;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.dstep = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (pos_q == POS_MANY) begin
					final_res = (k_q == 2'd3);
					case (k_q)
						2'd0: begin
							cmd.sel  = SEL_MID_SE;
							cmd.kind = KIND_CURVE;
						end
						2'd1: begin
							cmd.sel  = SEL_MID_X1;
							cmd.kind = KIND_CURVE;
						end
						2'd2: begin
							cmd.sel  = SEL_X1;
							cmd.kind = KIND_CURVE;
						end
						default: begin
							cmd.sel  = SEL_X2;
							cmd.kind = KIND_LINE;
						end
					endcase
				end else if (pos_q == POS_ONE) begin
					cmd.sel  = SEL_X2;
					cmd.kind = KIND_LINE;
				end
				cmd.run_end  = final_res;
				cmd.path_end = final_res && last_q;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (final_res) begin
						cmd.commit_prev = 1'b1;
						cmd.commit_se   = (pos_q == POS_ONE || pos_q == POS_MANY);
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= POS_EMPTY;
			mode_q  <= MODE_NONE;
			last_q  <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load_in) begin
				mode_q <= mode_d;
				last_q <= last_point;
				k_q    <= '0;
			end
			if (cmd.dinit) begin
				cnt_q <= CNTW'(COORD_WIDTH - 1);
			end else if (cmd.dstep) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.emit && final_res) begin
				if (last_q) begin
					pos_q <= POS_EMPTY;
				end else if (pos_q == POS_ONE || pos_q == POS_MANY) begin
					pos_q <= POS_MANY;
				end else begin
					pos_q <= POS_ONE;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CALC || state_q == ST_EMIT)
		else $error("accepted transaction did not start processing");
	a_pos_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("vertex position reached unused code");
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q != '0 |=> state_q == ST_DIV)
		else $error("divider left before its last step");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && pos_q != POS_MANY |-> k_q == 2'd0)
		else $error("extra result for a move or line transaction");
`endif

endmodule
`default_nettype wire

// ----- hdl/polyline_corner_rounding.sv -----
// Top level of the polyline corner rounding block: register port and core.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  vertex in | in_valid / in_ready  | point_x, point_y, last_point
//  result    | out_valid / out_ready| draw_kind, out_x, out_y, run_end, path_end
//  config    | APB psel/penable     | shorten_len at byte address 0
//
// A first vertex of a path goes straight to its result; every later vertex first passes
// the difference, multiply, divider-setup, divide and apply states, the bit-serial divider
// forming the minor-axis offset; then come its results: 1 for a line, 4 for a corner.
// A new vertex transaction is taken only once all results of the previous one are loaded
// into the output register; a stalled result holds the core in its emit state.
// Reset clears the path state, the previous vertex and segment end, and the shortening length.
`default_nettype none
module polyline_corner_rounding
	import pcr_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [0:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic                          last_point,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [1:0]                    draw_kind,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic                               run_end,
	output logic                               path_end
);

	logic [AMT_W-1:0] shorten_len_q;
	cmd_t             cmd;
	status_t          status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shorten_len_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_SHORTEN_LEN) begin
			shorten_len_q <= pwdata[AMT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SHORTEN_LEN) ? {1'b0, shorten_len_q} : 32'd0;

	pcr_ctrl #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_point(last_point),
		.status    (status),
		.cmd       (cmd)
	);

	pcr_datapath #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.shorten_len(shorten_len_q),
		.point_x    (point_x),
		.point_y    (point_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.draw_kind  (draw_kind),
		.out_x      (out_x),
		.out_y      (out_y),
		.run_end    (run_end),
		.path_end   (path_end)
	);

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the polyline corner rounding block.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
	logic [1:0]  kind;
	logic [31:0] x;
	logic [31:0] y;
	logic        run_end;
	logic        path_end;
} draw_item_t;

class CornerScoreboard;
	longint      amount;
	logic [1:0]  position;
	longint      prev_x, prev_y, end_x, end_y;
	draw_item_t  pending[$];
	int          errors;

	function new();
		amount = 0;
		position = pcr_pkg::POS_EMPTY;
		prev_x = 0;
		prev_y = 0;
		end_x = 0;
		end_y = 0;
		errors = 0;
	endfunction

	function void set_amount(logic [30:0] value);
		amount = value;
	endfunction

	function longint clamp(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function longint halfway(longint a, longint b);
		return (a < b) ? a + (b - a) / 2 : b + (a - b) / 2;
	endfunction

	function void shorten(inout longint x1, inout longint y1, inout longint x2,
			inout longint y2, input logic [1:0] mode);
		longint rise, dist_x, dist_y, major, off_x, off_y, sr, sx;
		rise = y1 - y2;
		dist_x = x1 - x2;
		dist_y = rise < 0 ? -rise : rise;
		major = dist_x < 0 ? -dist_x : dist_x;
		sr = rise < 0 ? -1 : 1;
		sx = dist_x < 0 ? -1 : 1;
		if (dist_y > major) major = dist_y;
		if (mode == pcr_pkg::MODE_BOTH && 2 * amount > major) begin
			x1 = x1 - dist_x / 2;
			y1 = y1 - rise / 2;
			x2 = x1;
			y2 = y1;
			return;
		end
		if (mode == pcr_pkg::MODE_START && amount > major) begin
			x1 = x2;
			y1 = y2;
			return;
		end
		if (mode == pcr_pkg::MODE_END && amount > major) begin
			x2 = x1;
			y2 = y1;
			return;
		end
		if (x1 == x2) begin
			off_x = 0;
			off_y = (y1 < y2) ? -amount : amount;
		end else if (y1 == y2) begin
			off_y = 0;
			off_x = (x1 < x2) ? -amount : amount;
		end else if (dist_y > sx * dist_x) begin
			// Both factors are nonnegative and the product stays below 2**63.
			off_y = sr * amount;
			off_x = sx * ((amount * (sx * dist_x)) / dist_y);
		end else if (dist_y < sx * dist_x) begin
			off_x = sx * amount;
			off_y = sr * ((amount * dist_y) / (sx * dist_x));
		end else begin
			off_x = 0;
			off_y = 0;
		end
		if (mode[1]) begin
			x2 = clamp(x2 + off_x);
			y2 = clamp(y2 + off_y);
		end
		if (mode[0]) begin
			x1 = clamp(x1 - off_x);
			y1 = clamp(y1 - off_y);
		end
	endfunction

	function void push(logic [1:0] kind, longint x, longint y, logic re, logic pe);
		draw_item_t item;
		item.kind = kind;
		item.x = x[31:0];
		item.y = y[31:0];
		item.run_end = re;
		item.path_end = pe;
		pending.insert(pending.size(), item);
	endfunction

	function void note_vertex(logic signed [31:0] px_in, logic signed [31:0] py_in,
			logic last);
		longint px, py, x1, y1, x2, y2;
		px = px_in;
		py = py_in;
		x1 = prev_x;
		y1 = prev_y;
		x2 = px;
		y2 = py;
		if (position == pcr_pkg::POS_ONE) begin
			if (!last) shorten(x1, y1, x2, y2, pcr_pkg::MODE_END);
			push(pcr_pkg::KIND_LINE, x2, y2, 1'b1, last);
		end else if (position == pcr_pkg::POS_MANY) begin
			shorten(x1, y1, x2, y2, last ? pcr_pkg::MODE_START : pcr_pkg::MODE_BOTH);
			push(pcr_pkg::KIND_CURVE, halfway(end_x, prev_x), halfway(end_y, prev_y),
				1'b0, 1'b0);
			push(pcr_pkg::KIND_CURVE, halfway(x1, prev_x), halfway(y1, prev_y), 1'b0, 1'b0);
			push(pcr_pkg::KIND_CURVE, x1, y1, 1'b0, 1'b0);
			push(pcr_pkg::KIND_LINE, x2, y2, 1'b1, last);
		end else begin
			push(pcr_pkg::KIND_MOVE, px, py, 1'b1, last);
		end
		if (position == pcr_pkg::POS_ONE || position == pcr_pkg::POS_MANY) begin
			end_x = x2;
			end_y = y2;
			position = pcr_pkg::POS_MANY;
		end else begin
			position = pcr_pkg::POS_ONE;
		end
		prev_x = px;
		prev_y = py;
		if (last) position = pcr_pkg::POS_EMPTY;
	endfunction

	function void check_result(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
			logic re, logic pe);
		draw_item_t exp_item;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: unexpected result kind=%0d x=%h y=%h", kind, x, y);
			return;
		end
		exp_item = pending.pop_front();
		if (kind !== exp_item.kind || x !== exp_item.x || y !== exp_item.y
				|| re !== exp_item.run_end || pe !== exp_item.path_end) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: expected kind=%0d x=%h y=%h re=%b pe=%b, got kind=%0d x=%h y=%h re=%b pe=%b",
					exp_item.kind, exp_item.x, exp_item.y, exp_item.run_end,
					exp_item.path_end, kind, x, y, re, pe);
		end
	endfunction
endclass

module testbench;
	import pcr_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [0:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] point_x = '0, point_y = '0;
	logic               last_point = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         draw_kind;
	logic signed [31:0] out_x, out_y;
	logic               run_end, path_end;

	CornerScoreboard    board = new();
	bit                 idling = 1'b1;
	int                 hold_len = 0;
	int                 quiet_cycles = 0;
	logic signed [31:0] last_x = 0, last_y = 0;

	polyline_corner_rounding u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.draw_kind(draw_kind), .out_x(out_x), .out_y(out_y),
		.run_end(run_end), .path_end(path_end)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_result(draw_kind, out_x, out_y, run_end, path_end);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 3000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver stalls in random bursts, or for one long stretch on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	task automatic write_amount(logic [30:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = REG_SHORTEN_LEN;
		pwdata = {1'b0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		board.set_amount(value);
	endtask

	task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
		if (idling && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		point_x = x;
		point_y = y;
		last_point = last;
		last_x = x;
		last_y = y;
		do @(posedge clk); while (!in_ready);
		board.note_vertex(x, y, last);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		// A vertex that produces no result yet may still be in the core.
		repeat (60) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_coord(logic signed [31:0] previous);
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return 0;
					default: return -1;
				endcase
			end
			3, 4: return previous;
			5: return previous + $signed($urandom_range(0, 512)) - 256;
			default: return $signed($urandom_range(0, 16383)) - 8192;
		endcase
	endfunction

	task automatic random_paths(int count);
		int sent, len;
		logic signed [31:0] x, y;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
			for (int i = 0; i < len; i++) begin
				x = pick_coord(last_x);
				y = pick_coord(last_y);
				send_vertex(x, y, i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_amount(31'h400);
		// Directed: one-point and two-point paths.
		send_vertex(32'sh100, 32'sh200, 1'b1);
		send_vertex(32'sh0, 32'sh0, 1'b0);
		send_vertex(32'sh3000, 32'sh1000, 1'b1);
		// Orthogonal corners, a steep and a flat slope, an exact diagonal.
		send_vertex(0, 0, 1'b0);
		send_vertex(0, 32'sh5000, 1'b0);
		send_vertex(32'sh5000, 32'sh5000, 1'b0);
		send_vertex(32'sh5800, 32'sh9000, 1'b0);
		send_vertex(32'sh9000, 32'sh9800, 1'b0);
		send_vertex(32'shC000, 32'shC800, 1'b0);
		send_vertex(32'shC100, 32'shC800, 1'b0);
		// Segments too short at both ends, then a repeated point.
		send_vertex(32'shC100, 32'shC900, 1'b0);
		send_vertex(32'shC100, 32'shC900, 1'b1);
		// Coordinate extremes.
		send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
		send_vertex(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
		send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
		send_vertex(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
		send_vertex(-1, 32'sh12345678, 1'b1);
		drain();

		write_amount(31'h7FFFFFFF);
		send_vertex(0, 0, 1'b0);
		send_vertex(32'sh7FFFFFFF, 32'sh100, 1'b0);
		send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
		send_vertex(32'sh100, 32'sh7FFFFFFF, 1'b1);
		random_paths(40);
		drain();

		write_amount(31'h0);
		hold_len = 400;
		random_paths(60);
		drain();

		write_amount(31'($urandom_range(1, 4096)));
		random_paths(110);
		drain();

		write_amount(31'($urandom));
		random_paths(60);
		drain();

		write_amount(31'($urandom_range(64, 1024)));
		random_paths(60);
		idling = 1'b0;
		random_paths(50);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/pcr_pkg.sv
hdl/pcr_datapath.sv
hdl/pcr_ctrl.sv
hdl/polyline_corner_rounding.sv
verif/testbench.sv
